// ===== rtl/core/pdzt_pkg.sv =====
// shared types and constants for the plane depth z-buffer test core
// no dependencies
package pdzt_pkg;

    localparam int DATA_W     = 32;
    localparam int FOCAL_W    = 10;
    localparam int WIDTH_W    = 10;
    localparam int HEIGHT_W   = 9;
    localparam int PX_W       = 9;
    localparam int PY_W       = 8;
    localparam int DELTA_W    = 11;
    localparam int PROD_W     = 44;
    localparam int DEN_W      = 46;
    localparam int NUM_W      = 43;
    localparam int NUM_SHIFT  = 17;
    localparam int DIVIDEND_W = NUM_W + NUM_SHIFT;
    localparam int PADDR_W    = 5;

    localparam logic [DATA_W-1:0] DEPTH_INF = '1;

    typedef enum logic [2:0] {
        REG_NORMAL_X       = 3'd0,
        REG_NORMAL_Y       = 3'd1,
        REG_NORMAL_Z       = 3'd2,
        REG_PLANE_CONSTANT = 3'd3,
        REG_FOCAL_LENGTH   = 3'd4,
        REG_SCREEN_WIDTH   = 3'd5,
        REG_SCREEN_HEIGHT  = 3'd6
    } reg_index_t;

    typedef enum logic [0:0] {
        OP_TEST  = 1'b0,
        OP_CLEAR = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_TEST,
        KIND_CLEAR,
        KIND_SKIP
    } kind_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_MX,
        ST_MY,
        ST_MZ,
        ST_NUM,
        ST_CHK,
        ST_DIV,
        ST_CMP,
        ST_EMIT
    } back_state_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

endpackage

// ===== rtl/core/pdzt_queue.sv =====
// two-entry transaction queue between front and back
// depends on nothing but its type parameter
module pdzt_queue #(
    parameter type entry_t = logic
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    input  logic   pop,
    output entry_t pop_data,
    output logic   full,
    output logic   empty
);

    entry_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/pdzt_front.sv =====
// front end: accepts pixel transactions, classifies them, forms offsets and store address
// depends on pdzt_pkg and pdzt_queue
module pdzt_front
    import pdzt_pkg::*;
#(
    parameter int X_SIZE = 512,
    parameter int Y_SIZE = 256,
    parameter int ADDR_W = 17
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                opcode,
    input  logic [PX_W-1:0]     pixel_x,
    input  logic [PY_W-1:0]     pixel_y,
    input  logic [WIDTH_W-1:0]  screen_width,
    input  logic [HEIGHT_W-1:0] screen_height,
    input  back_status_t        status,
    input  logic                pop,
    output logic                empty,
    output logic [1:0]          head_kind,
    output logic [DELTA_W-1:0]  head_dx2,
    output logic [DELTA_W-1:0]  head_dy2,
    output logic [ADDR_W-1:0]   head_addr
);

    typedef struct packed {
        kind_t               kind;
        logic [DELTA_W-1:0]  dx2;
        logic [DELTA_W-1:0]  dy2;
        logic [ADDR_W-1:0]   addr;
    } entry_t;

    entry_t new_entry;
    entry_t head;
    logic   full;
    logic   push;
    logic   in_range;

    assign in_ready = !full && !status.init_busy;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        in_range = (32'(pixel_x) < 32'(X_SIZE)) && (32'(pixel_y) < 32'(Y_SIZE));
        new_entry.dx2  = DELTA_W'({pixel_x, 1'b0}) - DELTA_W'(screen_width);
        new_entry.dy2  = DELTA_W'({pixel_y, 1'b0}) - DELTA_W'(screen_height);
        new_entry.addr = ADDR_W'(32'(pixel_x) * 32'(Y_SIZE) + 32'(pixel_y));
        if (opcode == OP_CLEAR)
        begin
            new_entry.kind = KIND_CLEAR;
        end
        else if (!in_range)
        begin
            new_entry.kind = KIND_SKIP;
        end
        else
        begin
            new_entry.kind = KIND_TEST;
        end
    end

    pdzt_queue #(
        .entry_t (entry_t)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (new_entry),
        .pop       (pop),
        .pop_data  (head),
        .full      (full),
        .empty     (empty)
    );

    assign head_kind = head.kind;
    assign head_dx2  = head.dx2;
    assign head_dy2  = head.dy2;
    assign head_addr = head.addr;

endmodule

// ===== rtl/core/pdzt_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on pdzt_pkg
module pdzt_div
    import pdzt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DEN_W-1:0]      divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [DEN_W:0]        rem_reg;
    logic [DEN_W:0]        rem_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DEN_W-1:0]      dsr_reg;
    logic [DEN_W-1:0]      dsr_next;
    logic [DEN_W:0]        trial;
    logic                  fits;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        trial     = {rem_reg[DEN_W-1:0], quo_reg[DIVIDEND_W-1]};
        fits      = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (trial - {1'b0, dsr_reg}) : trial;
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

endmodule

// ===== rtl/core/pdzt_back.sv =====
// back end: plane depth arithmetic, depth store, compare and update, result register
// depends on pdzt_pkg and pdzt_div
module pdzt_back
    import pdzt_pkg::*;
#(
    parameter int DEPTH  = 131072,
    parameter int ADDR_W = 17
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  logic [1:0]          head_kind,
    input  logic [DELTA_W-1:0]  head_dx2,
    input  logic [DELTA_W-1:0]  head_dy2,
    input  logic [ADDR_W-1:0]   head_addr,
    output logic                pop,
    output back_status_t        status,
    input  logic [DATA_W-1:0]   normal_x,
    input  logic [DATA_W-1:0]   normal_y,
    input  logic [DATA_W-1:0]   normal_z,
    input  logic [DATA_W-1:0]   plane_constant,
    input  logic [FOCAL_W-1:0]  focal_length,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                visible
);

    logic [DATA_W-1:0] mem [DEPTH];

    back_state_t state_reg;
    back_state_t state_next;

    logic                  init_reg;
    logic [ADDR_W-1:0]     sweep_cnt_reg;
    logic [1:0]            kind_reg;
    logic [DELTA_W-1:0]    dx2_reg;
    logic [DELTA_W-1:0]    dy2_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic signed [DEN_W-1:0] den_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic [DATA_W-1:0]     depth_reg;
    logic [DATA_W-1:0]     rd_data_reg;
    logic                  out_valid_reg;
    logic                  out_vis_reg;
    logic                  vis_reg;

    logic                  sweep_last;
    logic                  out_free;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [DATA_W-1:0]     mem_wdata;
    logic                  div_start;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DEN_W-1:0]      den_mag;
    logic [NUM_W-1:0]      num_mag;
    logic                  special;
    logic [DATA_W-1:0]     special_depth;
    logic [DATA_W-1:0]     div_depth;
    logic                  pass;
    logic signed [DATA_W-1:0]  mul_a;
    logic signed [DELTA_W:0]   mul_b;
    logic signed [PROD_W-1:0]  product;

    assign sweep_last = (sweep_cnt_reg == ADDR_W'(DEPTH - 1));
    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign visible    = out_vis_reg;
    assign status.init_busy = init_reg;

    // shared multiplier, one product per state
    always_comb
    begin
        case (state_reg)
            ST_MX:
            begin
                mul_a = signed'(normal_x);
                mul_b = signed'({dx2_reg[DELTA_W-1], dx2_reg});
            end
            ST_MY:
            begin
                mul_a = signed'(normal_y);
                mul_b = signed'({dy2_reg[DELTA_W-1], dy2_reg});
            end
            ST_MZ:
            begin
                mul_a = signed'(normal_z);
                mul_b = signed'({1'b0, focal_length, 1'b0});
            end
            default:
            begin
                mul_a = signed'(plane_constant);
                mul_b = signed'({2'b00, focal_length});
            end
        endcase
        product = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_comb
    begin
        den_mag  = den_reg[DEN_W-1] ? DEN_W'(-den_reg) : DEN_W'(den_reg);
        num_mag  = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        dividend = {num_mag, {NUM_SHIFT{1'b0}}};
        special  = 1'b1;
        if (den_reg == '0)
        begin
            special_depth = DEPTH_INF;
        end
        else if (num_reg == '0)
        begin
            special_depth = '0;
        end
        else if (num_reg[NUM_W-1] != den_reg[DEN_W-1])
        begin
            special_depth = DEPTH_INF;
        end
        else
        begin
            special_depth = DEPTH_INF;
            special       = 1'b0;
        end
        // anything above the largest finite depth saturates to infinity
        if (quotient[DIVIDEND_W-1:DATA_W] != '0)
        begin
            div_depth = DEPTH_INF;
        end
        else
        begin
            div_depth = quotient[DATA_W-1:0];
        end
        pass = (rd_data_reg >= depth_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = init_reg ? ST_IDLE : ST_EMIT;
                end
            end
            ST_IDLE:
            begin
                if (!empty)
                begin
                    case (head_kind)
                        KIND_CLEAR: state_next = ST_SWEEP;
                        KIND_TEST:  state_next = ST_MX;
                        default:    state_next = ST_EMIT;
                    endcase
                end
            end
            ST_MX:   state_next = ST_MY;
            ST_MY:   state_next = ST_MZ;
            ST_MZ:   state_next = ST_NUM;
            ST_NUM:  state_next = ST_CHK;
            ST_CHK:  state_next = special ? ST_CMP : ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop       = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = depth_reg;
        div_start = 1'b0;
        case (state_reg)
            ST_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_cnt_reg;
                mem_wdata = DEPTH_INF;
            end
            ST_IDLE:
            begin
                pop = !empty;
            end
            ST_CHK:
            begin
                div_start = !special;
            end
            ST_CMP:
            begin
                mem_we = pass;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            init_reg      <= 1'b1;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SWEEP)
            begin
                sweep_cnt_reg <= sweep_last ? '0 : sweep_cnt_reg + 1'b1;
                if (sweep_last)
                begin
                    init_reg <= 1'b0;
                end
            end
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= head_kind;
            dx2_reg  <= head_dx2;
            dy2_reg  <= head_dy2;
            addr_reg <= head_addr;
            vis_reg  <= 1'b0;
        end
        case (state_reg)
            ST_MX:  den_reg <= DEN_W'(product);
            ST_MY:  den_reg <= den_reg + DEN_W'(product);
            ST_MZ:  den_reg <= den_reg + DEN_W'(product);
            ST_NUM: num_reg <= NUM_W'(product);
            ST_CHK: depth_reg <= special_depth;
            ST_DIV:
            begin
                if (div_done)
                begin
                    depth_reg <= div_depth;
                end
            end
            ST_CMP: vis_reg <= pass;
            default:
            begin
                num_reg <= num_reg;
            end
        endcase
        if (state_reg == ST_EMIT && out_free)
        begin
            out_vis_reg <= vis_reg && (kind_reg == KIND_TEST);
        end
    end

    // depth store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[addr_reg];
    end

    pdzt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (den_mag),
        .done     (div_done),
        .quotient (quotient)
    );

endmodule

// ===== rtl/core/plane_depth_zbuffer_test_core.sv =====
// top level of the plane depth z-buffer test core: register file, front, back
// depends on pdzt_pkg, pdzt_front, pdzt_back
//
//  channel   direction  handshake                  payload
//  in        sink       in_valid / in_ready        opcode, pixel_x, pixel_y
//  out       source     out_valid / out_ready      visible
//  apb       sink       psel, penable, pwrite      paddr, pwdata, prdata
//
// a test transaction goes through the back end from pop to result in this order: one pop,
// four products on the shared multiplier, one check, the one-bit-per-cycle divider (60
// quotient bits, then done), compare and result; a special-case depth skips the divider;
// the result waits while out is stalled
// out-of-range transactions go from pop straight to result; a clear first sweeps the store
// after reset the store is swept to the infinity code, X_SIZE*Y_SIZE entries, in_ready low
// a two-entry queue lets the front take transactions while the back works or out stalls
module plane_depth_zbuffer_test_core
    import pdzt_pkg::*;
#(
    parameter int X_SIZE = 512,
    parameter int Y_SIZE = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [PX_W-1:0]    pixel_x,
    input  logic [PY_W-1:0]    pixel_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               visible,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    localparam int DEPTH  = X_SIZE * Y_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);

    // plane and screen registers
    logic [DATA_W-1:0]   normal_x_reg;
    logic [DATA_W-1:0]   normal_y_reg;
    logic [DATA_W-1:0]   normal_z_reg;
    logic [DATA_W-1:0]   plane_constant_reg;
    logic [FOCAL_W-1:0]  focal_length_reg;
    logic [WIDTH_W-1:0]  screen_width_reg;
    logic [HEIGHT_W-1:0] screen_height_reg;

    logic               wr_en;
    reg_index_t         reg_idx;
    back_status_t       status;
    logic               pop;
    logic               empty;
    logic [1:0]         head_kind;
    logic [DELTA_W-1:0] head_dx2;
    logic [DELTA_W-1:0] head_dy2;
    logic [ADDR_W-1:0]  head_addr;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_index_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg       <= '0;
            normal_y_reg       <= '0;
            normal_z_reg       <= '0;
            plane_constant_reg <= '0;
            focal_length_reg   <= '0;
            screen_width_reg   <= WIDTH_W'(512);
            screen_height_reg  <= HEIGHT_W'(256);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_NORMAL_X:       normal_x_reg       <= pwdata;
                REG_NORMAL_Y:       normal_y_reg       <= pwdata;
                REG_NORMAL_Z:       normal_z_reg       <= pwdata;
                REG_PLANE_CONSTANT: plane_constant_reg <= pwdata;
                REG_FOCAL_LENGTH:   focal_length_reg   <= pwdata[FOCAL_W-1:0];
                REG_SCREEN_WIDTH:   screen_width_reg   <= pwdata[WIDTH_W-1:0];
                REG_SCREEN_HEIGHT:  screen_height_reg  <= pwdata[HEIGHT_W-1:0];
                default:            normal_x_reg       <= normal_x_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            REG_NORMAL_X:       prdata = normal_x_reg;
            REG_NORMAL_Y:       prdata = normal_y_reg;
            REG_NORMAL_Z:       prdata = normal_z_reg;
            REG_PLANE_CONSTANT: prdata = plane_constant_reg;
            REG_FOCAL_LENGTH:   prdata = DATA_W'(focal_length_reg);
            REG_SCREEN_WIDTH:   prdata = DATA_W'(screen_width_reg);
            REG_SCREEN_HEIGHT:  prdata = DATA_W'(screen_height_reg);
            default:            prdata = '0;
        endcase
    end

    // front: classify and queue transactions
    pdzt_front #(
        .X_SIZE (X_SIZE),
        .Y_SIZE (Y_SIZE),
        .ADDR_W (ADDR_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .status        (status),
        .pop           (pop),
        .empty         (empty),
        .head_kind     (head_kind),
        .head_dx2      (head_dx2),
        .head_dy2      (head_dy2),
        .head_addr     (head_addr)
    );

    // back: depth math, store update, result register
    pdzt_back #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .empty          (empty),
        .head_kind      (head_kind),
        .head_dx2       (head_dx2),
        .head_dy2       (head_dy2),
        .head_addr      (head_addr),
        .pop            (pop),
        .status         (status),
        .normal_x       (normal_x_reg),
        .normal_y       (normal_y_reg),
        .normal_z       (normal_z_reg),
        .plane_constant (plane_constant_reg),
        .focal_length   (focal_length_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .visible        (visible)
    );

endmodule
